// File: rtl/core/base45_encoder_assert.svh
// Assertion macros shared by the Base45 encoder checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BASE45_ENCODER_ASSERT_SVH
`define BASE45_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B45_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("base45 encoder check failed");

// Next-cycle implication, disabled while reset is high.
`define B45_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("base45 encoder check failed");

`endif

// File: rtl/core/b45_pkg.sv
// Types, constants and the alphabet lookup of the Base45 encoder.
// Used by the front end, the queue, the back end and the top level.
package b45_pkg;

   localparam logic [6:0] DIGIT_BASE  = 7'd48;
   localparam logic [6:0] LETTER_BASE = 7'd55;

   // One encoding group waiting for the back end.
   typedef struct packed {
      logic [15:0] value;
      logic        three_chars;
      logic        last;
   } group_type;

   function automatic logic [6:0] b45_char(input logic [5:0] digit);
      logic [6:0] ch;
      ch = 7'd32;
      if (digit < 6'd10) begin
         ch = DIGIT_BASE + {1'b0, digit};
      end else if (digit < 6'd36) begin
         ch = LETTER_BASE + {1'b0, digit};
      end else begin
         case (digit)
            6'd36:   ch = 7'd32;
            6'd37:   ch = 7'd36;
            6'd38:   ch = 7'd37;
            6'd39:   ch = 7'd42;
            6'd40:   ch = 7'd43;
            6'd41:   ch = 7'd45;
            6'd42:   ch = 7'd46;
            6'd43:   ch = 7'd47;
            6'd44:   ch = 7'd58;
            default: ch = 7'd32;
         endcase
      end
      return ch;
   endfunction

endpackage

// File: rtl/core/base45_encoder.sv
// Base45 encoder top level: front end, group queue and character back end.
// Depends on b45_pkg, b45_front, b45_queue and b45_back.

// Bytes enter on the request channel with an end-of-message flag; every pair of
// bytes leaves as three Base45 characters and a lone final byte as two, least
// significant digit first. The first byte of a pair is taken and only held.
// Complete groups wait in a small queue, so bytes keep flowing while the output
// is stalled, until the queue fills. The back end produces exactly one character
// per cycle while the output is not stalled, from one 16x16 reciprocal multiply.
// A group passes through the queue, the back-end work register and the output
// register before its first character appears.
module base45_encoder
   import b45_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_message_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_symbol,
   output logic       rsp_group_end,
   output logic       rsp_message_done
);

   group_type push_data, pop_data;
   logic      push, pop, queue_full, queue_empty;

   b45_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .push            (push),
      .push_data       (push_data),
      .queue_full      (queue_full)
   );

   b45_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   b45_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .pop_data         (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_group_end    (rsp_group_end),
      .rsp_message_done (rsp_message_done)
   );

endmodule

// File: rtl/core/b45_queue.sv
// Short first-in first-out queue of encoding groups between front and back end.
// Depends on b45_pkg for the group type.
module b45_queue
   import b45_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output group_type pop_data,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   group_type     store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/b45_front.sv
// Front end: accepts message bytes, pairs them and forms encoding groups.
// Depends on b45_pkg for the group type.
module b45_front
   import b45_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_message_end,
   output logic       push,
   output group_type  push_data,
   input  logic       queue_full
);

   logic       holding_ff, holding_in;
   logic [7:0] held_ff, held_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      holding_in = holding_ff;
      held_in    = held_ff;
      push       = 1'b0;
      push_data  = '{value: {8'd0, req_data_byte}, three_chars: 1'b0, last: 1'b1};
      if (holding_ff) begin
         push_data = '{value: {held_ff, req_data_byte}, three_chars: 1'b1,
                       last: req_message_end};
      end
      if (accept) begin
         if (!holding_ff && !req_message_end) begin
            holding_in = 1'b1;
            held_in    = req_data_byte;
         end else begin
            // A completed pair or a lone final byte is pushed as a group; nothing stays held.
            push       = 1'b1;
            holding_in = 1'b0;
            held_in    = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         held_ff    <= 8'd0;
      end else begin
         holding_ff <= holding_in;
         held_ff    <= held_in;
      end
   end

endmodule

// File: rtl/core/b45_back.sv
// Back end: splits each group into base-45 digits, one character per cycle while the output is not stalled.
// Depends on b45_pkg for the group type and the alphabet lookup.
module b45_back
   import b45_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  group_type  pop_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_symbol,
   output logic       rsp_group_end,
   output logic       rsp_message_done
);

   // floor(w / 45) = (w * 46604) >> 21 holds exactly for every 16-bit w.
   localparam logic [15:0] RECIP = 16'd46604;
   localparam int          SHIFT = 21;

   logic        active_ff, active_in;
   logic [15:0] work_ff, work_in;
   logic [1:0]  left_ff, left_in;
   logic        last_ff, last_in;
   logic        valid_ff, valid_in;
   logic [6:0]  symbol_ff, symbol_in;
   logic        grp_ff, grp_in;
   logic        done_ff, done_in;

   logic [31:0] product;
   logic [10:0] quot;
   logic [16:0] quot_x45;
   logic [15:0] rem_full;
   logic        out_free, emit, finishing;

   assign product  = work_ff * RECIP;
   assign quot     = product[31:SHIFT];
   assign quot_x45 = {1'b0, quot, 5'd0} + {3'b0, quot, 3'd0} + {4'b0, quot, 2'd0}
                   + {6'b0, quot};
   assign rem_full = work_ff - quot_x45[15:0];

   assign out_free  = !valid_ff || rsp_ready;
   assign emit      = active_ff && out_free;
   assign finishing = emit && (left_ff == 2'd1);
   assign pop       = !queue_empty && (!active_ff || finishing);

   always_comb begin
      active_in = active_ff;
      work_in   = work_ff;
      left_in   = left_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && !rsp_ready;
      symbol_in = symbol_ff;
      grp_in    = grp_ff;
      done_in   = done_ff;
      if (emit) begin
         valid_in  = 1'b1;
         symbol_in = b45_char(rem_full[5:0]);
         grp_in    = finishing;
         done_in   = finishing && last_ff;
         work_in   = {5'd0, quot};
         left_in   = left_ff - 2'd1;
         if (finishing) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         work_in   = pop_data.value;
         left_in   = pop_data.three_chars ? 2'd3 : 2'd2;
         last_in   = pop_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         left_ff   <= 2'd0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      last_ff   <= last_in;
      symbol_ff <= symbol_in;
      grp_ff    <= grp_in;
      done_ff   <= done_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = symbol_ff;
   assign rsp_group_end    = grp_ff;
   assign rsp_message_done = done_ff;

endmodule

// File: rtl/core/b45_checker.sv
// Port-level checks of the Base45 encoder, bound to the top level.
// Depends on base45_encoder_assert.svh for the assertion macros.
`include "base45_encoder_assert.svh"

module b45_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_message_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_symbol,
   input logic       rsp_group_end,
   input logic       rsp_message_done
);

   // A stalled character must hold still until it is taken.
   `B45_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_symbol) && $stable(rsp_group_end) && $stable(rsp_message_done))

   // The end of a message always closes a group.
   `B45_ASSERT_NOW(a_done_closes_group, rsp_valid && rsp_message_done, rsp_group_end)

   // Every character lies in the printable range of the alphabet.
   `B45_ASSERT_NOW(a_symbol_range, rsp_valid,
      (rsp_symbol >= 7'd32) && (rsp_symbol <= 7'd90))

   // A waiting request keeps its byte and flag until it is taken.
   `B45_ASSERT_NEXT(a_req_hold, req_valid && !req_ready,
      req_valid && $stable(req_data_byte) && $stable(req_message_end))

endmodule

bind base45_encoder b45_checker u_b45_checker (.*);
